/* src/csls_pkg.sv */
package csls_pkg;

  localparam int unsigned FieldBits = 20;

  localparam logic [7:0] ChLineFeed = 8'd10;
  localparam logic [7:0] ChSlash    = 8'd47;
  localparam logic [7:0] ChStar     = 8'd42;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_SLASH = 2'd1,
    KIND_STAR  = 2'd2,
    KIND_OTHER = 2'd3
  } char_kind_e;

  typedef struct packed {
    logic                 last;
    logic [FieldBits-1:0] line;
    logic [FieldBits-1:0] length;
    logic [FieldBits-1:0] start;
  } seg_t;

  // Segments produced by one source byte, packed from slot 0 up.
  typedef struct packed {
    logic [1:0] cnt;
    seg_t       seg0;
    seg_t       seg1;
  } push_t;

endpackage

/* src/csls_core.sv */
module csls_core import csls_pkg::*; #(
  parameter int unsigned OFFSET_BITS = 20
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  logic [7:0] byte_i,
  input  logic       eos_i,
  output push_t      push_o
);

  localparam logic [OFFSET_BITS-1:0] MaxVal = '1;

  typedef logic [OFFSET_BITS-1:0] ofs_t;

  ofs_t       offset_q, offset_d;
  ofs_t       line_q, line_d;
  ofs_t       begin_q, begin_d;
  ofs_t       end_q, end_d;
  logic       in_block_q, in_block_d;
  logic       in_line_q, in_line_d;
  char_kind_e kind_q, kind_d;

  function automatic ofs_t sat_inc(input ofs_t v);
    return (v == MaxVal) ? MaxVal : v + ofs_t'(1);
  endfunction

  function automatic ofs_t sat_dec(input ofs_t v);
    return (v == '0) ? '0 : v - ofs_t'(1);
  endfunction

  function automatic logic [FieldBits-1:0] fld(input ofs_t v);
    logic [31:0] w;
    w = 32'(v);
    return w[FieldBits-1:0];
  endfunction

  function automatic seg_t make_seg(input ofs_t s, input ofs_t e, input ofs_t l);
    seg_t r;
    r.start  = fld(s);
    r.length = fld((e > s) ? e - s : '0);
    r.line   = fld(l);
    r.last   = 1'b0;
    return r;
  endfunction

  function automatic char_kind_e kind_of(input logic [7:0] c);
    if (c == ChSlash) return KIND_SLASH;
    if (c == ChStar) return KIND_STAR;
    return KIND_OTHER;
  endfunction

  always_comb begin
    logic  emit_a, emit_b;
    seg_t  seg_a, seg_b;
    ofs_t  p, p_inc;
    emit_a     = 1'b0;
    emit_b     = 1'b0;
    seg_a      = '0;
    seg_b      = '0;
    p          = offset_q;
    p_inc      = sat_inc(offset_q);
    line_d     = line_q;
    begin_d    = begin_q;
    end_d      = end_q;
    in_block_d = in_block_q;
    in_line_d  = in_line_q;
    kind_d     = kind_q;

    if (byte_i == ChLineFeed) begin
      emit_a    = !in_block_q;
      seg_a     = make_seg(begin_q, in_line_q ? end_q : p, line_q);
      begin_d   = p_inc;
      line_d    = sat_inc(line_q);
      kind_d    = KIND_NONE;
      in_line_d = 1'b0;
      emit_b    = eos_i && !in_block_q;
      seg_b     = make_seg(p_inc, p_inc, sat_inc(line_q));
    end else begin
      if (in_line_q) begin
        // The rest of the line is a comment.
      end else if (in_block_q) begin
        if (kind_q == KIND_STAR && byte_i == ChSlash) begin
          in_block_d = 1'b0;
          begin_d    = p_inc;
          kind_d     = KIND_NONE;
        end else begin
          kind_d = kind_of(byte_i);
        end
      end else if (kind_q == KIND_SLASH && byte_i == ChSlash) begin
        in_line_d = 1'b1;
        end_d     = sat_dec(p);
      end else if (kind_q == KIND_SLASH && byte_i == ChStar) begin
        emit_a     = 1'b1;
        seg_a      = make_seg(begin_q, sat_dec(p), line_q);
        in_block_d = 1'b1;
        kind_d     = KIND_NONE;
      end else begin
        kind_d = kind_of(byte_i);
      end
      emit_b = eos_i && !in_block_d;
      seg_b  = make_seg(begin_d, in_line_d ? end_d : p_inc, line_q);
    end

    // The final segment of a source carries the last flag.
    seg_b.last = eos_i;
    if (!emit_b) begin
      seg_a.last = eos_i;
    end

    push_o = '0;
    if (valid_i) begin
      push_o.cnt = {1'b0, emit_a} + {1'b0, emit_b};
      if (emit_a) begin
        push_o.seg0 = seg_a;
        push_o.seg1 = seg_b;
      end else begin
        push_o.seg0 = seg_b;
      end
    end

    offset_d = p_inc;
    if (eos_i) begin
      offset_d   = '0;
      line_d     = '0;
      begin_d    = '0;
      end_d      = '0;
      in_block_d = 1'b0;
      in_line_d  = 1'b0;
      kind_d     = KIND_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q   <= '0;
      line_q     <= '0;
      begin_q    <= '0;
      end_q      <= '0;
      in_block_q <= 1'b0;
      in_line_q  <= 1'b0;
      kind_q     <= KIND_NONE;
    end else if (valid_i) begin
      offset_q   <= offset_d;
      line_q     <= line_d;
      begin_q    <= begin_d;
      end_q      <= end_d;
      in_block_q <= in_block_d;
      in_line_q  <= in_line_d;
      kind_q     <= kind_d;
    end
  end

endmodule

/* src/csls_out_buf.sv */
module csls_out_buf import csls_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  input  logic  pop_i,
  output logic  room_o,
  output logic  valid_o,
  output seg_t  head_o
);

  localparam int unsigned Depth = 3;

  seg_t       slot_q [Depth];
  seg_t       slot_d [Depth];
  logic [1:0] count_q, count_d;

  always_comb begin
    seg_t       sh [Depth];
    logic [1:0] cnt_p;
    cnt_p = count_q - {1'b0, pop_i};
    for (int i = 0; i < Depth; i++) begin
      if (pop_i && i < Depth - 1) begin
        sh[i] = slot_q[i+1];
      end else begin
        sh[i] = slot_q[i];
      end
    end
    for (int i = 0; i < Depth; i++) begin
      slot_d[i] = sh[i];
      if (push_i.cnt != 2'd0 && 2'(i) == cnt_p) begin
        slot_d[i] = push_i.seg0;
      end
      if (push_i.cnt == 2'd2 && 2'(i) == cnt_p + 2'd1) begin
        slot_d[i] = push_i.seg1;
      end
    end
    count_d = cnt_p + push_i.cnt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Depth; i++) begin
      slot_q[i] <= slot_d[i];
    end
  end

  // Room for the two segments a single byte can produce.
  assign room_o  = (count_q <= 2'd1);
  assign valid_o = (count_q != 2'd0);
  assign head_o  = slot_q[0];

endmodule

/* src/comment_stripping_line_splitter.sv */
// Splits a C-style source text, one byte per beat, into line segments with the
// comments removed. Each output beat gives the start offset, length and line
// number of one kept piece of code; tlast marks the final segment of a source,
// and the beat after an input tlast starts a new source at offset zero. One
// input byte is taken per cycle when the sink keeps up: a byte passes an input
// register, the combinational scanning logic and a three-entry result queue.
// A byte can yield two segments (a line feed ending the source), so the input
// pauses while the queue holds two or more.
module comment_stripping_line_splitter import csls_pkg::*; #(
  parameter int unsigned OFFSET_BITS = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // source_byte
  input  logic        s_axis_tlast,  // end_of_source
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // segment_start, segment_length, line_index, 4'b0
  output logic        m_axis_tlast   // last_segment
);

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_eos_q;
  logic       room;
  logic       advance;
  push_t      push;
  seg_t       head;

  assign advance       = in_valid_q && room;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_eos_q  <= s_axis_tlast;
    end
  end

  csls_core #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(advance),
    .byte_i (in_byte_q),
    .eos_i  (in_eos_q),
    .push_o (push)
  );

  csls_out_buf u_out_buf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (m_axis_tvalid && m_axis_tready),
    .room_o (room),
    .valid_o(m_axis_tvalid),
    .head_o (head)
  );

  assign m_axis_tdata = {4'b0, head.line, head.length, head.start};
  assign m_axis_tlast = head.last;

endmodule

/* test/comment_stripping_line_splitter_tb.sv */
`timescale 1ns / 1ps

module comment_stripping_line_splitter_tb;
  import csls_pkg::*;

  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned StallLimit  = 3000;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned RandomBytes = 620;
  localparam logic [FieldBits-1:0] OffsetMax = '1;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // source_byte
  logic        s_axis_tlast;   // end_of_source
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;   // segment_start, segment_length, line_index, 4'b0
  logic        m_axis_tlast;   // last_segment

  comment_stripping_line_splitter #(
    .OFFSET_BITS(FieldBits)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Scanner state mirrored from the block.
  logic [FieldBits-1:0] pos;
  logic [FieldBits-1:0] line_no;
  logic [FieldBits-1:0] seg_begin;
  logic [FieldBits-1:0] seg_stop;
  logic                 in_block;
  logic                 in_line;
  char_kind_e           prev_kind;

  seg_t       segments_due[$];
  logic [7:0] src[$];
  int         errors;
  int         bytes_sent;
  int         quiet_cycles;
  bit         tx_idle_en;
  bit         rx_idle_en;
  bit         hold_req;
  seg_t       got;
  seg_t       want;

  function automatic logic [FieldBits-1:0] sat_up(input logic [FieldBits-1:0] v);
    return (v == OffsetMax) ? v : v + 1'b1;
  endfunction

  function automatic logic [FieldBits-1:0] sat_down(input logic [FieldBits-1:0] v);
    return (v == '0) ? v : v - 1'b1;
  endfunction

  function automatic char_kind_e kind_of(input logic [7:0] c);
    if (c == ChSlash) return KIND_SLASH;
    if (c == ChStar) return KIND_STAR;
    return KIND_OTHER;
  endfunction

  function automatic seg_t make_seg(input logic [FieldBits-1:0] first,
                                    input logic [FieldBits-1:0] stop,
                                    input logic [FieldBits-1:0] line);
    seg_t s;
    s.start  = first;
    s.length = (stop > first) ? stop - first : '0;
    s.line   = line;
    s.last   = 1'b0;
    return s;
  endfunction

  task automatic clear_scan_state();
    pos       = '0;
    line_no   = '0;
    seg_begin = '0;
    seg_stop  = '0;
    in_block  = 1'b0;
    in_line   = 1'b0;
    prev_kind = KIND_NONE;
  endtask

  // Works out the segments caused by one accepted source byte.
  task automatic track_source_byte(input logic [7:0] c, input logic eos);
    seg_t                 found[2];
    int                   n;
    logic [FieldBits-1:0] p;
    n = 0;
    p = pos;
    if (c == ChLineFeed) begin
      if (!in_block) begin
        found[n] = make_seg(seg_begin, in_line ? seg_stop : p, line_no);
        n++;
      end
      seg_begin = sat_up(p);
      line_no   = sat_up(line_no);
      prev_kind = KIND_NONE;
      in_line   = 1'b0;
      // A final line feed opens one more, empty line.
      if (eos && !in_block) begin
        found[n] = make_seg(seg_begin, seg_begin, line_no);
        n++;
      end
    end else begin
      if (!in_line) begin
        if (in_block) begin
          if (prev_kind == KIND_STAR && c == ChSlash) begin
            in_block  = 1'b0;
            seg_begin = sat_up(p);
            prev_kind = KIND_NONE;
          end else begin
            prev_kind = kind_of(c);
          end
        end else if (prev_kind == KIND_SLASH && c == ChSlash) begin
          in_line  = 1'b1;
          seg_stop = sat_down(p);
        end else if (prev_kind == KIND_SLASH && c == ChStar) begin
          found[n] = make_seg(seg_begin, sat_down(p), line_no);
          n++;
          in_block  = 1'b1;
          prev_kind = KIND_NONE;
        end else begin
          prev_kind = kind_of(c);
        end
      end
      if (eos && !in_block) begin
        found[n] = make_seg(seg_begin, in_line ? seg_stop : sat_up(p), line_no);
        n++;
      end
    end
    pos = sat_up(p);
    if (eos) begin
      if (n > 0) found[n-1].last = 1'b1;
      clear_scan_state();
    end
    for (int i = 0; i < n; i++) segments_due.insert(segments_due.size(), found[i]);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic eos);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eos;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    track_source_byte(b, eos);
    bytes_sent++;
  endtask

  task automatic send_source();
    for (int i = 0; i < src.size(); i++) send_byte(src[i], i == src.size() - 1);
    src.delete();
  endtask

  task automatic add_byte(input logic [7:0] b);
    src.insert(src.size(), b);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic add_word();
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(0, 4) == 0) add_byte(8'h20);
      else add_byte(8'h61 + 8'($urandom_range(0, 25)));
    end
  endtask

  // Mostly C-like tokens, with stray slashes, stars, closers and raw bytes mixed in.
  task automatic build_source();
    repeat ($urandom_range(3, 25)) begin
      case ($urandom_range(0, 10))
        0, 1, 2: add_word();
        3, 4:    add_byte(ChLineFeed);
        5: begin
          add_text("//");
          add_word();
        end
        6: begin
          add_text("/*");
          repeat ($urandom_range(0, 6)) begin
            case ($urandom_range(0, 3))
              0:       add_byte(ChStar);
              1:       add_byte(ChSlash);
              2:       add_byte(ChLineFeed);
              default: add_byte(8'h78);
            endcase
          end
          add_text("*/");
        end
        7: add_byte(8'($urandom_range(0, 255)));
        8: add_byte(($urandom_range(0, 1) != 0) ? ChSlash : ChStar);
        9: add_text("*/");
        default: add_text("/*");
      endcase
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (segments_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic test_directed();
    // Line comment, an empty line and a final line feed.
    add_text("a//b\n\n");
    send_source();
    // A line wholly inside a block comment, closed on the last line.
    add_text("c/*\nz\n*/");
    send_source();
    // The star of the opener is not reused to close; extreme byte values.
    add_text("/*/");
    add_byte(8'hFF);
    add_text("*/");
    add_byte(8'h00);
    add_byte(ChLineFeed);
    send_source();
    // No pair is seen across a line break.
    add_text("/\n/x");
    send_source();
    // The source ends inside a block comment.
    add_text("k/*");
    send_source();
    drain();
  endtask

  task automatic test_random_sources();
    while (bytes_sent < RandomBytes) begin
      tx_idle_en = ($urandom_range(0, 4) != 0);
      rx_idle_en = ($urandom_range(0, 4) != 0);
      build_source();
      send_source();
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    drain();
  endtask

  task automatic test_back_pressure();
    tx_idle_en = 1'b0;
    hold_req   = 1'b1;
    repeat (20) add_text("ab\n");
    send_source();
    tx_idle_en = 1'b1;
    drain();
  endtask

  // Sink side: a random wait before each beat when idles are enabled, and one long hold when asked.
  initial begin
    int n;
    m_axis_tready = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end
      n = rx_idle_en ? $urandom_range(0, 6) : 0;
      if (n > 0) begin
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.start  = m_axis_tdata[FieldBits-1:0];
      got.length = m_axis_tdata[2*FieldBits-1:FieldBits];
      got.line   = m_axis_tdata[3*FieldBits-1:2*FieldBits];
      got.last   = m_axis_tlast;
      if (segments_due.size() == 0) begin
        $error("unexpected segment: start %0d length %0d line %0d",
               got.start, got.length, got.line);
        errors++;
      end else begin
        want = segments_due.pop_front();
        if (got.start !== want.start) begin
          $error("segment_start expected %0d got %0d", want.start, got.start);
          errors++;
        end
        if (got.length !== want.length) begin
          $error("segment_length expected %0d got %0d", want.length, got.length);
          errors++;
        end
        if (got.line !== want.line) begin
          $error("line_index expected %0d got %0d", want.line, got.line);
          errors++;
        end
        if (got.last !== want.last) begin
          $error("last_segment expected %0d got %0d", want.last, got.last);
          errors++;
        end
      end
    end
  end

  // Ends the run when neither side moves a beat for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == StallLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    errors        = 0;
    bytes_sent    = 0;
    tx_idle_en    = 1'b1;
    rx_idle_en    = 1'b1;
    hold_req      = 1'b0;
    clear_scan_state();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_back_pressure();
    test_random_sources();
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* files.f */
src/csls_pkg.sv
src/csls_core.sv
src/csls_out_buf.sv
src/comment_stripping_line_splitter.sv
test/comment_stripping_line_splitter_tb.sv
